>>> src/rjr_pkg.sv
// Package with the shared types, constants and the JSON scanner step for the reassembler.
package rjr_pkg;

	localparam int MSG_BYTES = 1024;
	localparam int FRAG_MAX = 62;
	localparam int NEST_LIMIT = 16;
	localparam int ADDR_W = $clog2(MSG_BYTES);
	localparam int STORE_BYTES = 2 * MSG_BYTES;
	localparam int STORE_W = $clog2(STORE_BYTES);
	localparam int DEPTH_W = $clog2(NEST_LIMIT + 2);
	localparam int PREFIX_LEN = 9;

	localparam logic [7:0] REPORT_TYPE = 8'd2;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef struct packed {
		logic action;
		logic [7:0] data_byte;
		logic report_last;
		logic [9:0] read_index;
	} in_t;

	typedef struct packed {
		logic result_kind;
		logic accepted;
		logic complete;
		logic [9:0] message_length;
		logic [7:0] read_byte;
	} out_t;

	typedef struct packed {
		logic started;
		logic in_str;
		logic esc;
		logic closed;
		logic trailing;
		logic [DEPTH_W-1:0] depth;
	} scan_t;

	typedef struct packed {
		scan_t s;
		logic ovf;
	} scan_res_t;

	typedef struct packed {
		logic we;
		logic [STORE_W-1:0] addr;
		logic [7:0] data;
	} wr_t;

	typedef struct packed {
		logic accepted;
		logic complete;
		logic [ADDR_W-1:0] length;
		logic in_range;
	} status_t;

	function automatic logic [7:0] prefix_byte(logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = 8'h7B;
			4'd1: r = 8'h22;
			4'd2: r = 8'h6D;
			4'd3: r = 8'h65;
			4'd4: r = 8'h74;
			4'd5: r = 8'h68;
			4'd6: r = 8'h6F;
			4'd7: r = 8'h64;
			4'd8: r = 8'h22;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic scan_res_t scan_step(scan_t s, logic [7:0] c);
		scan_res_t r;
		r.s = s;
		r.ovf = 1'b0;
		if (s.closed) begin
			if (!is_space(c))
				r.s.trailing = 1'b1;
		end else if (!s.started) begin
			if (c == CH_LBRACE) begin
				r.s.started = 1'b1;
				r.s.depth = DEPTH_W'(1);
			end
		end else if (s.in_str) begin
			if (s.esc)
				r.s.esc = 1'b0;
			else if (c == CH_BSLASH)
				r.s.esc = 1'b1;
			else if (c == CH_QUOTE)
				r.s.in_str = 1'b0;
		end else if (c == CH_QUOTE) begin
			r.s.in_str = 1'b1;
		end else if (c == CH_LBRACE || c == CH_LBRACK) begin
			r.s.depth = s.depth + DEPTH_W'(1);
			if (r.s.depth > DEPTH_W'(NEST_LIMIT))
				r.ovf = 1'b1;
		end else if (c == CH_RBRACE || c == CH_RBRACK) begin
			if (s.depth != '0)
				r.s.depth = s.depth - DEPTH_W'(1);
			if (r.s.depth == '0)
				r.s.closed = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> src/report_json_reassembler_unit.sv
// A result beat passes the first register stage and then the output register.
// Throughput: one beat per cycle unless out_ready stalls; the store read port feeds stage one.
// Reset: asynchronous; the message is empty and report_id is one after reset.
// The message store holds no reset; only bytes below the committed length are read.
// The store is a ring of twice the message size, so a pending fragment never hits committed bytes.
// Top level of the report JSON reassembler with result pipeline and output register.
module report_json_reassembler_unit
	import rjr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data,
	input logic cfg_we,
	input logic [7:0] cfg_data
);

	logic take, push, rd, adv;
	wr_t wr;
	logic [STORE_W-1:0] raddr;
	status_t status;
	logic [7:0] rdata;
	logic v_s1, kind_s1;
	status_t st_s1;

	assign adv = !out_valid || out_ready;
	assign in_ready = !v_s1 || adv;
	assign take = in_valid && in_ready;
	assign push = take && in_data.action == ACT_PUSH;
	assign rd = take && in_data.action == ACT_READ;

	rjr_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.push(push),
		.data_byte(in_data.data_byte),
		.report_last(in_data.report_last),
		.read_index(in_data.read_index),
		.wr(wr),
		.raddr(raddr),
		.status(status)
	);

	rjr_store u_store (
		.clk(clk),
		.wr(wr),
		.re(rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= rd || (push && in_data.report_last);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= in_data.action;
			st_s1 <= status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_data.result_kind <= kind_s1;
			out_data.accepted <= kind_s1 == KIND_STATUS && st_s1.accepted;
			out_data.complete <= kind_s1 == KIND_STATUS && st_s1.complete;
			out_data.message_length <= 10'(st_s1.length);
			out_data.read_byte <= (kind_s1 == KIND_READ && st_s1.in_range) ? rdata : 8'd0;
		end
	end

`ifndef SYNTHESIS
	a_complete_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.complete |-> out_data.accepted)
		else $error("complete without accepted");
	a_read_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_READ |-> !out_data.accepted && !out_data.complete)
		else $error("read result carries status flags");
	a_read_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rd |=> v_s1 && kind_s1 == KIND_READ)
		else $error("read beat lost before first stage");
`endif

endmodule

>>> src/rjr_store.sv
// Message byte store with one write port and one registered read port.
module rjr_store
	import rjr_pkg::*;
(
	input logic clk,
	input wr_t wr,
	input logic re,
	input logic [STORE_W-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [STORE_BYTES];

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> src/rjr_frame.sv
// Report header parsing, incremental JSON scanning and message commit logic.
module rjr_frame
	import rjr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_data,
	input logic push,
	input logic [7:0] data_byte,
	input logic report_last,
	input logic [9:0] read_index,
	output wr_t wr,
	output logic [STORE_W-1:0] raddr,
	output status_t status
);

	logic [7:0] report_id_q;
	logic [1:0] pos_q, pos_n;
	logic [7:0] hdr0_q, hdr0_n, hdr1_q, hdr1_n;
	logic bad_q, bad_n;
	logic [7:0] fs_q, fs_n, wc_q, wc_n;
	logic [3:0] prog_q, prog_n;
	scan_t work_q, work_n, fresh_q, fresh_n, cscan_q, cscan_n;
	logic wbad_q, wbad_n, fbad_q, fbad_n;
	logic [ADDR_W-1:0] count_q, count_n;
	logic [STORE_W-1:0] start_q, start_n;

	logic strip, feed, restart, sbad;
	logic [7:0] rtype, plen;
	logic [ADDR_W-1:0] base;
	scan_t sc;
	scan_res_t wres, fres;

	always_comb begin
		pos_n = pos_q;
		hdr0_n = hdr0_q;
		hdr1_n = hdr1_q;
		bad_n = bad_q;
		fs_n = fs_q;
		wc_n = wc_q;
		prog_n = prog_q;
		work_n = work_q;
		fresh_n = fresh_q;
		wbad_n = wbad_q;
		fbad_n = fbad_q;
		cscan_n = cscan_q;
		count_n = count_q;
		start_n = start_q;
		wr = '0;
		feed = 1'b0;
		strip = 1'b0;
		rtype = '0;
		plen = '0;
		restart = 1'b0;
		sbad = 1'b0;
		base = '0;
		sc = '0;
		wres = scan_step(work_q, data_byte);
		fres = scan_step(fresh_q, data_byte);
		status.accepted = 1'b0;
		status.complete = 1'b0;
		status.length = count_q;
		status.in_range = ADDR_W'(read_index) < count_q;
		raddr = start_q + STORE_W'(read_index);
		if (push) begin
			case (pos_q)
				2'd0: hdr0_n = data_byte;
				2'd1: hdr1_n = data_byte;
				2'd2: begin
					strip = hdr0_q == report_id_q;
					rtype = strip ? hdr1_q : hdr0_q;
					plen = strip ? data_byte : hdr1_q;
					bad_n = rtype != REPORT_TYPE || plen > 8'(FRAG_MAX);
					fs_n = bad_n ? 8'd0 : plen;
					feed = !strip && !bad_n;
				end
				default: feed = !bad_q;
			endcase
			if (feed && wc_q < fs_n) begin
				wr.we = 1'b1;
				wr.addr = start_q + STORE_W'(count_q) + STORE_W'(wc_q);
				wr.data = data_byte;
				if (wc_q < 8'(PREFIX_LEN) && prog_q == wc_q[3:0]
						&& data_byte == prefix_byte(wc_q[3:0]))
					prog_n = prog_q + 4'd1;
				if (!wbad_q) begin
					work_n = wres.s;
					wbad_n = wres.ovf;
				end
				if (!fbad_q) begin
					fresh_n = fres.s;
					fbad_n = fres.ovf;
				end
				wc_n = wc_q + 8'd1;
			end
			if (!report_last) begin
				pos_n = (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;
			end else begin
				if (pos_q == 2'd1) begin
					status.accepted = hdr0_q == REPORT_TYPE && data_byte == 8'd0;
					status.complete = status.accepted && cscan_q.closed && !cscan_q.trailing;
				end else if (pos_q != 2'd0 && !(bad_n || wc_n < fs_n)) begin
					restart = prog_n == 4'(PREFIX_LEN) && count_q != '0;
					base = restart ? '0 : count_q;
					sc = restart ? fresh_n : work_n;
					sbad = restart ? fbad_n : wbad_n;
					if ((ADDR_W + 1)'(base) + (ADDR_W + 1)'(fs_n) >= (ADDR_W + 1)'(MSG_BYTES)
							|| sbad) begin
						count_n = '0;
						cscan_n = '0;
					end else begin
						if (restart)
							start_n = start_q + STORE_W'(count_q);
						count_n = base + ADDR_W'(fs_n);
						cscan_n = sc;
						status.accepted = 1'b1;
						status.complete = sc.closed && !sc.trailing;
					end
				end
				status.length = count_n;
				pos_n = '0;
				bad_n = 1'b0;
				fs_n = '0;
				wc_n = '0;
				prog_n = '0;
				work_n = cscan_n;
				wbad_n = 1'b0;
				fresh_n = '0;
				fbad_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_id_q <= 8'd1;
			pos_q <= '0;
			hdr0_q <= '0;
			hdr1_q <= '0;
			bad_q <= 1'b0;
			fs_q <= '0;
			wc_q <= '0;
			prog_q <= '0;
			work_q <= '0;
			fresh_q <= '0;
			wbad_q <= 1'b0;
			fbad_q <= 1'b0;
			cscan_q <= '0;
			count_q <= '0;
			start_q <= '0;
		end else begin
			if (cfg_we)
				report_id_q <= cfg_data;
			pos_q <= pos_n;
			hdr0_q <= hdr0_n;
			hdr1_q <= hdr1_n;
			bad_q <= bad_n;
			fs_q <= fs_n;
			wc_q <= wc_n;
			prog_q <= prog_n;
			work_q <= work_n;
			fresh_q <= fresh_n;
			wbad_q <= wbad_n;
			fbad_q <= fbad_n;
			cscan_q <= cscan_n;
			count_q <= count_n;
			start_q <= start_n;
		end
	end

endmodule

>>> dv/report_json_reassembler_unit_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the reassembler's status and read beats.
module report_json_reassembler_unit_checker
	import rjr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data,
	input logic cfg_we,
	input logic [7:0] cfg_data,
	output int errors,
	output int pending
);

	typedef struct {
		bit started;
		bit in_str;
		bit esc;
		bit closed;
		bit trailing;
		int depth;
	} json_pos_t;

	localparam string METHOD_TAG = "{\"method\"";

	logic [7:0] msg_mem [MSG_BYTES];
	logic [7:0] frag_buf [FRAG_MAX];
	logic [7:0] id_byte;
	int msg_len;
	int frag_fill;
	json_pos_t msg_pos, work_pos, fresh_pos;
	bit work_nest_bad, fresh_nest_bad;
	int beat_pos;
	logic [15:0] hdr;
	int frag_len;
	int tag_match;
	bit hdr_bad;
	bit id_seen;
	out_t expected_beats [$];

	function automatic bit json_advance(ref json_pos_t s, input logic [7:0] c);
		bit ws;
		ws = c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB;
		if (s.closed) begin
			if (!ws)
				s.trailing = 1;
			return 0;
		end
		if (!s.started) begin
			if (c == CH_LBRACE) begin
				s.started = 1;
				s.depth = 1;
			end
			return 0;
		end
		if (s.in_str) begin
			if (s.esc)
				s.esc = 0;
			else if (c == CH_BSLASH)
				s.esc = 1;
			else if (c == CH_QUOTE)
				s.in_str = 0;
			return 0;
		end
		if (c == CH_QUOTE) begin
			s.in_str = 1;
		end else if (c == CH_LBRACE || c == CH_LBRACK) begin
			s.depth++;
			if (s.depth > NEST_LIMIT)
				return 1;
		end else if (c == CH_RBRACE || c == CH_RBRACK) begin
			if (s.depth > 0)
				s.depth--;
			if (s.depth == 0)
				s.closed = 1;
		end
		return 0;
	endfunction

	function automatic json_pos_t empty_pos();
		json_pos_t p;
		p = '{default: 0};
		return p;
	endfunction

	task automatic start_report();
		beat_pos = 0;
		hdr = '0;
		frag_len = 0;
		tag_match = 0;
		hdr_bad = 0;
		id_seen = 0;
		frag_fill = 0;
		work_pos = msg_pos;
		work_nest_bad = 0;
		fresh_pos = empty_pos();
		fresh_nest_bad = 0;
	endtask

	task automatic take_payload(logic [7:0] b);
		if (frag_fill >= frag_len || frag_fill >= FRAG_MAX)
			return;
		frag_buf[frag_fill] = b;
		if (frag_fill < PREFIX_LEN && tag_match == frag_fill && b == METHOD_TAG[frag_fill])
			tag_match++;
		if (!work_nest_bad)
			work_nest_bad = json_advance(work_pos, b);
		if (!fresh_nest_bad)
			fresh_nest_bad = json_advance(fresh_pos, b);
		frag_fill++;
	endtask

	task automatic close_report(int n, output bit acc, output bit comp);
		bit restart, bad;
		int base;
		json_pos_t s;
		acc = 0;
		comp = 0;
		if (n < 2)
			return;
		if (n == 2) begin
			if (hdr[7:0] == REPORT_TYPE && hdr[15:8] == 8'd0) begin
				acc = 1;
				comp = msg_pos.closed && !msg_pos.trailing;
			end
			return;
		end
		if (hdr_bad || frag_fill < frag_len)
			return;
		restart = tag_match == PREFIX_LEN && msg_len != 0;
		base = restart ? 0 : msg_len;
		s = restart ? fresh_pos : work_pos;
		bad = restart ? fresh_nest_bad : work_nest_bad;
		if (base + frag_len >= MSG_BYTES || bad) begin
			msg_len = 0;
			msg_pos = empty_pos();
			return;
		end
		for (int i = 0; i < frag_len; i++)
			msg_mem[base + i] = frag_buf[i];
		msg_len = base + frag_len;
		msg_pos = s;
		acc = 1;
		comp = s.closed && !s.trailing;
	endtask

	task automatic absorb_beat(in_t it);
		out_t e;
		logic [7:0] r0, r1, typ, plen;
		bit acc, comp;
		e = '0;
		if (it.action == ACT_READ) begin
			e.result_kind = KIND_READ;
			e.message_length = msg_len[9:0];
			e.read_byte = int'(it.read_index) < msg_len ? msg_mem[it.read_index] : 8'd0;
			expected_beats.push_back(e);
			return;
		end
		if (beat_pos == 0) begin
			hdr = {8'd0, it.data_byte};
		end else if (beat_pos == 1) begin
			hdr[15:8] = it.data_byte;
		end else if (beat_pos == 2) begin
			r0 = hdr[7:0];
			r1 = hdr[15:8];
			if (r0 == id_byte) begin
				id_seen = 1;
				typ = r1;
				plen = it.data_byte;
			end else begin
				typ = r0;
				plen = r1;
			end
			hdr_bad = typ != REPORT_TYPE || plen > FRAG_MAX;
			frag_len = hdr_bad ? 0 : plen;
			if (!id_seen && !hdr_bad)
				take_payload(it.data_byte);
		end else if (!hdr_bad) begin
			take_payload(it.data_byte);
		end
		if (!it.report_last) begin
			if (beat_pos < 16'hFFFF)
				beat_pos++;
			return;
		end
		close_report(beat_pos + 1, acc, comp);
		start_report();
		e.result_kind = KIND_STATUS;
		e.accepted = acc;
		e.complete = comp;
		e.message_length = msg_len[9:0];
		expected_beats.push_back(e);
	endtask

	task automatic report_mismatch(string what, out_t got, out_t want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			id_byte = 8'd1;
			msg_len = 0;
			msg_pos = empty_pos();
			start_report();
			expected_beats.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", out_data, '0);
				end else begin
					want = expected_beats.pop_front();
					if (out_data.result_kind != want.result_kind)
						report_mismatch("result_kind", out_data, want);
					if (out_data.accepted != want.accepted)
						report_mismatch("accepted", out_data, want);
					if (out_data.complete != want.complete)
						report_mismatch("complete", out_data, want);
					if (out_data.message_length != want.message_length)
						report_mismatch("message_length", out_data, want);
					if (out_data.read_byte != want.read_byte)
						report_mismatch("read_byte", out_data, want);
				end
			end
			if (in_valid && in_ready)
				absorb_beat(in_data);
			if (cfg_we)
				id_byte = cfg_data;
		end
		pending = expected_beats.size();
	end

endmodule

>>> dv/report_json_reassembler_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top that drives reports and reads into the reassembler and gives the verdict.
module report_json_reassembler_unit_tb;
	import rjr_pkg::*;

	localparam logic [7:0] METHOD_BYTES [9] = '{8'h7B, 8'h22, 8'h6D, 8'h65, 8'h74, 8'h68,
		8'h6F, 8'h64, 8'h22};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_we;
	logic [7:0] cfg_data;
	int errors;
	int pending;
	int idle_in;
	int idle_out;
	int beats;
	int quiet_cycles;
	logic [7:0] cur_id;
	logic [7:0] msg_text [$];

	report_json_reassembler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	report_json_reassembler_unit_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			out_ready <= $urandom_range(99) >= idle_out;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 5000) begin
			$display("report_json_reassembler_unit verification failed");
			$finish;
		end
	end

	task automatic send_beat(in_t it);
		while ($urandom_range(99) < idle_in) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		beats++;
		@(negedge clk);
	endtask

	task automatic send_report(logic [7:0] q [$]);
		in_t it;
		foreach (q[i]) begin
			it.action = ACT_PUSH;
			it.data_byte = q[i];
			it.report_last = i == q.size() - 1;
			it.read_index = 10'($urandom);
			send_beat(it);
		end
	endtask

	task automatic send_read(int idx);
		in_t it;
		it.action = ACT_READ;
		it.data_byte = 8'($urandom);
		it.report_last = 1'($urandom);
		it.read_index = 10'(idx);
		send_beat(it);
	endtask

	task automatic send_fragment(bit with_id, logic [7:0] body [$]);
		logic [7:0] q [$];
		if (with_id)
			q.push_back(cur_id);
		q.push_back(REPORT_TYPE);
		q.push_back(8'(body.size()));
		foreach (body[i])
			q.push_back(body[i]);
		send_report(q);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			msg_text.push_back(s[i]);
	endtask

	task automatic make_message();
		logic [7:0] closers [$];
		int levels;
		if ($urandom_range(9) == 0)
			add_text("x ");
		if ($urandom_range(2) == 0)
			add_text("{\"method\":\"run\",");
		else
			add_text("{\"id\":7,");
		levels = $urandom_range(9) == 0 ? $urandom_range(14, 18) : $urandom_range(0, 3);
		for (int l = 0; l < levels; l++) begin
			if ($urandom_range(1)) begin
				add_text("\"k\":[");
				closers.push_back(CH_RBRACK);
			end else begin
				add_text("\"o\":{");
				closers.push_back(CH_RBRACE);
			end
		end
		add_text("\"s\":\"a\\\"{b\\\\\"");
		repeat ($urandom_range(0, 6))
			msg_text.push_back(8'($urandom));
		while (closers.size() > 0)
			msg_text.push_back(closers.pop_back());
		msg_text.push_back(CH_RBRACE);
		case ($urandom_range(3))
			0: add_text(" \r\n\t");
			1: msg_text.push_back(CH_NUL);
			2: add_text(" z");
			default: ;
		endcase
	endtask

	task automatic random_report();
		logic [7:0] body [$];
		logic [7:0] q [$];
		int n;
		int pick;
		pick = $urandom_range(99);
		if (pick < 75) begin
			if (msg_text.size() == 0)
				make_message();
			n = $urandom_range(1, FRAG_MAX);
			while (n > 0 && msg_text.size() > 0) begin
				body.push_back(msg_text.pop_front());
				n--;
			end
			send_fragment($urandom_range(1), body);
		end else if (pick < 85) begin
			n = $urandom_range(1, 8);
			repeat (n)
				q.push_back(8'($urandom));
			send_report(q);
		end else if (pick < 92) begin
			q = '{REPORT_TYPE, 8'($urandom_range(5, FRAG_MAX))};
			repeat ($urandom_range(0, 3))
				q.push_back(8'h61);
			send_report(q);
		end else begin
			q = '{REPORT_TYPE, 8'($urandom_range(0, 3)), 8'h7B, 8'h7D};
			repeat ($urandom_range(0, 4))
				q.push_back(8'($urandom));
			send_report(q);
		end
		if ($urandom_range(3) == 0)
			send_read($urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(80));
	endtask

	task automatic settle_and_write(logic [7:0] v);
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		cur_id = v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		logic [7:0] body [$];
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_data = '0;
		beats = 0;
		quiet_cycles = 0;
		cur_id = 8'd1;
		idle_in = 24;
		idle_out = 54;
		repeat (7) @(negedge clk);
		arst_n = 1;
		settle_and_write(8'd1);

		send_read(0);
		send_report('{8'h02});
		send_report('{REPORT_TYPE, 8'h00});
		send_report('{REPORT_TYPE, 8'h01});
		send_report('{8'h03, 8'h01, 8'h41});
		send_report('{REPORT_TYPE, 8'd63, 8'h41});
		send_report('{REPORT_TYPE, 8'd5, 8'h7B, 8'h7D});
		send_fragment(1, '{8'h7B, 8'h22, 8'h61, 8'h5C, 8'h22, 8'h22, 8'h3A, 8'h5B});
		send_fragment(0, '{8'h5D, 8'h7D, 8'h20, 8'h0D, 8'h0A, 8'h09, 8'h00});
		send_read(1);
		send_read(1023);
		send_report('{8'h01, REPORT_TYPE, 8'd2, 8'h20, 8'h7E, 8'hFF, 8'h55});
		body = '{};
		foreach (METHOD_BYTES[i])
			body.push_back(METHOD_BYTES[i]);
		body.push_back(8'h7D);
		send_fragment(1, body);
		body = '{};
		repeat (18)
			body.push_back(8'h5B);
		send_fragment(0, body);
		send_read(5);

		for (int ph = 0; ph < 3; ph++) begin
			idle_in = ph == 0 ? 24 : ph == 1 ? 54 : 0;
			idle_out = ph == 0 ? 54 : ph == 1 ? 24 : 0;
			if (ph == 1)
				settle_and_write(8'd0);
			if (ph == 2)
				settle_and_write(8'hFF);
			msg_text.delete();
			beats = 0;
			while (beats < 240)
				random_report();
		end
		settle_and_write(REPORT_TYPE);
		repeat (4)
			random_report();

		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("report_json_reassembler_unit verification clean");
		else
			$display("report_json_reassembler_unit verification failed");
		$finish;
	end

endmodule

>>> files.f
src/rjr_pkg.sv
src/rjr_store.sv
src/rjr_frame.sv
src/report_json_reassembler_unit.sv
dv/report_json_reassembler_unit_checker.sv
dv/report_json_reassembler_unit_tb.sv
